// File: sv/assert_macros.svh
// Assertion helpers for the lexer block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent on the next clock edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/lex_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lex_pkg
// Scanner states, token kinds, character classes, keyword table and the
// single automaton step used by the lexer module.
// ----------------------------------------------------------------------------
package lex_pkg;

    localparam int LEXEME_MAX    = 32;
    localparam int LEN_W         = 6;
    localparam int KEYWORD_COUNT = 30;
    localparam int KW_MAX_LEN    = 13;
    localparam int LINE_W        = 16;

    localparam logic [4:0] ST_START    = 5'd0;
    localparam logic [4:0] ST_SLASH    = 5'd1;
    localparam logic [4:0] ST_LINECOM  = 5'd2;
    localparam logic [4:0] ST_BLKCOM   = 5'd3;
    localparam logic [4:0] ST_BLKSTAR  = 5'd4;
    localparam logic [4:0] ST_GT       = 5'd5;
    localparam logic [4:0] ST_LT       = 5'd6;
    localparam logic [4:0] ST_EQ       = 5'd7;
    localparam logic [4:0] ST_AMP      = 5'd8;
    localparam logic [4:0] ST_BAR      = 5'd9;
    localparam logic [4:0] ST_DEC      = 5'd10;
    localparam logic [4:0] ST_DEC_U    = 5'd11;
    localparam logic [4:0] ST_DEC_UL   = 5'd12;
    localparam logic [4:0] ST_DOT      = 5'd13;
    localparam logic [4:0] ST_FRAC     = 5'd14;
    localparam logic [4:0] ST_EXP      = 5'd15;
    localparam logic [4:0] ST_EXPSIGN  = 5'd16;
    localparam logic [4:0] ST_EXPDIG   = 5'd17;
    localparam logic [4:0] ST_ZERO     = 5'd18;
    localparam logic [4:0] ST_HEX0     = 5'd19;
    localparam logic [4:0] ST_OCT      = 5'd20;
    localparam logic [4:0] ST_OCT_SUF  = 5'd21;
    localparam logic [4:0] ST_HEX      = 5'd22;
    localparam logic [4:0] ST_HEX_L    = 5'd23;
    localparam logic [4:0] ST_HEX_U    = 5'd24;
    localparam logic [4:0] ST_HEX_UL   = 5'd25;
    localparam logic [4:0] ST_IDENT    = 5'd26;
    localparam logic [4:0] ST_STRING   = 5'd27;

    localparam logic [4:0] K_ERR     = 5'd0;
    localparam logic [4:0] K_END     = 5'd1;
    localparam logic [4:0] K_IDENT   = 5'd2;
    localparam logic [4:0] K_KEYWORD = 5'd3;
    localparam logic [4:0] K_NUM     = 5'd4;
    localparam logic [4:0] K_STR     = 5'd5;
    localparam logic [4:0] K_PLUS    = 5'd6;
    localparam logic [4:0] K_MINUS   = 5'd7;
    localparam logic [4:0] K_STAR    = 5'd8;
    localparam logic [4:0] K_LPAR    = 5'd9;
    localparam logic [4:0] K_RPAR    = 5'd10;
    localparam logic [4:0] K_LBRK    = 5'd11;
    localparam logic [4:0] K_RBRK    = 5'd12;
    localparam logic [4:0] K_LBRC    = 5'd13;
    localparam logic [4:0] K_RBRC    = 5'd14;
    localparam logic [4:0] K_COMMA   = 5'd15;
    localparam logic [4:0] K_SEMI    = 5'd16;
    localparam logic [4:0] K_COLON   = 5'd17;
    localparam logic [4:0] K_SLASH   = 5'd18;
    localparam logic [4:0] K_ASSIGN  = 5'd19;
    localparam logic [4:0] K_EQEQ    = 5'd20;
    localparam logic [4:0] K_LT      = 5'd21;
    localparam logic [4:0] K_LE      = 5'd22;
    localparam logic [4:0] K_NE      = 5'd23;
    localparam logic [4:0] K_GT      = 5'd24;
    localparam logic [4:0] K_GE      = 5'd25;
    localparam logic [4:0] K_ANDAND  = 5'd26;
    localparam logic [4:0] K_OROR    = 5'd27;

    localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KEYWORD_COUNT] = '{
        "funcion", "acceso", "arreglo", "cadena", "caracter", "clase", "comienzo",
        "de", "entero", "entonces", "fin", "hacer", "hasta", "mientras", "para",
        "procedimiento", "programa", "real", "repetir", "si", "sino", "var",
        "retornar", "privado", "publico", "protegido", "seleccionar", "caso",
        "interrumpir", "alcontrario"
    };

    localparam logic [LEN_W-1:0] KW_LEN [KEYWORD_COUNT] = '{
        6'd7, 6'd6, 6'd7, 6'd6, 6'd8, 6'd5, 6'd8, 6'd2, 6'd6, 6'd8, 6'd3, 6'd5,
        6'd5, 6'd8, 6'd4, 6'd13, 6'd8, 6'd4, 6'd7, 6'd2, 6'd4, 6'd3, 6'd8, 6'd7,
        6'd7, 6'd9, 6'd11, 6'd4, 6'd11, 6'd11
    };

    typedef struct packed {
        logic [4:0] kind;
        logic [4:0] keyword_index;
        logic [5:0] lexeme_length;
        logic [15:0] line_number;
        logic        last_of_run;
    } token_t;

    typedef struct packed {
        logic   push0;
        logic   push1;
        token_t tok0;
        token_t tok1;
    } push_t;

    typedef struct packed {
        logic [4:0] next_state;
        logic       keep;
        logic       done;
        logic       again;
        logic [4:0] kind;
    } step_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic [4:0] single_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            "+":     k = K_PLUS;
            "-":     k = K_MINUS;
            "*":     k = K_STAR;
            "(":     k = K_LPAR;
            ")":     k = K_RPAR;
            "[":     k = K_LBRK;
            "]":     k = K_RBRK;
            "{":     k = K_LBRC;
            "}":     k = K_RBRC;
            ",":     k = K_COMMA;
            ";":     k = K_SEMI;
            ":":     k = K_COLON;
            default: k = K_ERR;
        endcase
        return k;
    endfunction

    function automatic step_t scan_step(input logic [4:0] st, input logic [7:0] c,
                                        input logic eof);
        step_t r;
        logic  dig;
        logic  al;
        dig = !eof && is_digit(c);
        al  = !eof && is_alpha(c);
        r.next_state = st;
        r.keep  = 1'b0;
        r.done  = 1'b0;
        r.again = 1'b0;
        r.kind  = K_ERR;
        case (st)
            ST_START:
            begin
                if (eof)
                begin
                    r.done = 1'b1;
                    r.kind = K_END;
                end
                else if (c == "0")
                begin
                    r.keep = 1'b1;
                    r.next_state = ST_ZERO;
                end
                else if (dig)
                begin
                    r.keep = 1'b1;
                    r.next_state = ST_DEC;
                end
                else if (c == ".")
                begin
                    r.keep = 1'b1;
                    r.next_state = ST_DOT;
                end
                else if (al || c == "_")
                begin
                    r.keep = 1'b1;
                    r.next_state = ST_IDENT;
                end
                else if (c == " " || c == 8'h09 || c == 8'h0A)
                begin
                    r.next_state = ST_START;
                end
                else if (c == "\"") r.next_state = ST_STRING;
                else if (c == "/") r.next_state = ST_SLASH;
                else if (c == ">") r.next_state = ST_GT;
                else if (c == "<") r.next_state = ST_LT;
                else if (c == "=") r.next_state = ST_EQ;
                else if (c == "&") r.next_state = ST_AMP;
                else if (c == "|") r.next_state = ST_BAR;
                else
                begin
                    r.keep = 1'b1;
                    r.done = 1'b1;
                    r.kind = single_kind(c);
                end
            end
            ST_AMP, ST_BAR:
            begin
                r.done = 1'b1;
                if (!eof && st == ST_BAR && c == "|") r.kind = K_OROR;
                else if (!eof && st == ST_AMP && c == "&") r.kind = K_ANDAND;
                else r.again = eof;
            end
            ST_EQ:
            begin
                r.done = 1'b1;
                if (!eof && c == "=") r.kind = K_EQEQ;
                else
                begin
                    r.kind = K_ASSIGN;
                    r.again = 1'b1;
                end
            end
            ST_LT:
            begin
                r.done = 1'b1;
                if (!eof && c == "=") r.kind = K_LE;
                else if (!eof && c == ">") r.kind = K_NE;
                else
                begin
                    r.kind = K_LT;
                    r.again = 1'b1;
                end
            end
            ST_GT:
            begin
                r.done = 1'b1;
                if (!eof && c == "=") r.kind = K_GE;
                else
                begin
                    r.kind = K_GT;
                    r.again = 1'b1;
                end
            end
            ST_SLASH:
            begin
                if (!eof && c == "*") r.next_state = ST_BLKCOM;
                else if (!eof && c == "/") r.next_state = ST_LINECOM;
                else
                begin
                    r.done = 1'b1;
                    r.again = 1'b1;
                    r.kind = K_SLASH;
                end
            end
            ST_LINECOM:
            begin
                if (eof)
                begin
                    r.done = 1'b1;
                    r.again = 1'b1;
                end
                else if (c == 8'h0A) r.next_state = ST_START;
            end
            ST_BLKCOM:
            begin
                if (eof)
                begin
                    r.done = 1'b1;
                    r.again = 1'b1;
                end
                else if (c == "*") r.next_state = ST_BLKSTAR;
            end
            ST_BLKSTAR:
            begin
                if (eof)
                begin
                    r.done = 1'b1;
                    r.again = 1'b1;
                end
                else if (c == "/") r.next_state = ST_START;
                else if (c != "*") r.next_state = ST_BLKCOM;
            end
            ST_DEC:
            begin
                if (dig) r.keep = 1'b1;
                else if (!eof && (c == "e" || c == "E"))
                begin
                    r.keep = 1'b1;
                    r.next_state = ST_EXP;
                end
                else if (!eof && c == "U")
                begin
                    r.keep = 1'b1;
                    r.next_state = ST_DEC_U;
                end
                else
                begin
                    r.done = 1'b1;
                    r.again = 1'b1;
                    r.kind = K_NUM;
                end
            end
            ST_DEC_U, ST_HEX_U:
            begin
                if (!eof && c == "L")
                begin
                    r.keep = 1'b1;
                    r.next_state = (st == ST_DEC_U) ? ST_DEC_UL : ST_HEX_UL;
                end
                else
                begin
                    r.done = 1'b1;
                    r.again = 1'b1;
                    r.kind = K_NUM;
                end
            end
            ST_DOT:
            begin
                if (dig)
                begin
                    r.keep = 1'b1;
                    r.next_state = ST_FRAC;
                end
                else
                begin
                    r.done = 1'b1;
                    r.again = 1'b1;
                    r.kind = K_NUM;
                end
            end
            ST_FRAC:
            begin
                if (dig) r.keep = 1'b1;
                else if (!eof && (c == "e" || c == "E"))
                begin
                    r.keep = 1'b1;
                    r.next_state = ST_EXP;
                end
                else
                begin
                    r.done = 1'b1;
                    r.again = 1'b1;
                    r.kind = K_NUM;
                end
            end
            ST_EXP:
            begin
                if (!eof && (c == "+" || c == "-"))
                begin
                    r.keep = 1'b1;
                    r.next_state = ST_EXPSIGN;
                end
                else
                begin
                    r.done = 1'b1;
                    r.again = 1'b1;
                end
            end
            ST_EXPSIGN, ST_HEX0:
            begin
                if (dig)
                begin
                    r.keep = 1'b1;
                    r.next_state = (st == ST_EXPSIGN) ? ST_EXPDIG : ST_HEX;
                end
                else
                begin
                    r.done = 1'b1;
                    r.again = 1'b1;
                end
            end
            ST_EXPDIG:
            begin
                if (dig) r.keep = 1'b1;
                else
                begin
                    r.done = 1'b1;
                    r.again = 1'b1;
                    r.kind = K_NUM;
                end
            end
            ST_ZERO:
            begin
                if (dig)
                begin
                    r.keep = 1'b1;
                    r.next_state = ST_OCT;
                end
                else if (!eof && (c == "x" || c == "X"))
                begin
                    r.keep = 1'b1;
                    r.next_state = ST_HEX0;
                end
                else
                begin
                    r.done = 1'b1;
                    r.again = 1'b1;
                    r.kind = K_NUM;
                end
            end
            ST_OCT:
            begin
                if (dig) r.keep = 1'b1;
                else if (!eof && (c == "L" || c == "U"))
                begin
                    r.keep = 1'b1;
                    r.next_state = ST_OCT_SUF;
                end
                else
                begin
                    r.done = 1'b1;
                    r.again = 1'b1;
                    r.kind = K_NUM;
                end
            end
            ST_HEX:
            begin
                if (dig) r.keep = 1'b1;
                else if (!eof && c == "L")
                begin
                    r.keep = 1'b1;
                    r.next_state = ST_HEX_L;
                end
                else if (!eof && c == "U")
                begin
                    r.keep = 1'b1;
                    r.next_state = ST_HEX_U;
                end
                else
                begin
                    r.done = 1'b1;
                    r.again = 1'b1;
                    r.kind = K_NUM;
                end
            end
            ST_IDENT:
            begin
                if (al || dig || (!eof && c == "_")) r.keep = 1'b1;
                else
                begin
                    r.done = 1'b1;
                    r.again = 1'b1;
                    r.kind = K_IDENT;
                end
            end
            ST_STRING:
            begin
                if (eof)
                begin
                    r.done = 1'b1;
                    r.again = 1'b1;
                end
                else if (c == "\"")
                begin
                    r.done = 1'b1;
                    r.kind = K_STR;
                end
                else r.keep = 1'b1;
            end
            default:
            begin
                r.done = 1'b1;
                r.again = 1'b1;
                r.kind = K_NUM;
            end
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: sv/source_lexer_with_keywords.sv
`default_nettype none
// ----------------------------------------------------------------------------
// source_lexer_with_keywords
// Character stream lexer with reserved-word recognition.
// ----------------------------------------------------------------------------
// One character beat enters per cycle: the automaton step, the rescan of a
// terminating character and the parallel keyword compare are combinational
// between the scanner state registers and a four-entry token queue.
// A beat may yield up to two token beats; input stalls only while the queue
// holds more than two tokens, so the sustained rate is one beat per cycle
// whenever the output side keeps up.
module source_lexer_with_keywords
    import lex_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_byte
    input  wire logic [0:0]  s_tuser,   // [0] end_of_input
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // kind, keyword_index, lexeme_length, line_number
    output logic             m_tlast    // last_of_run
);

    logic [4:0]        state_reg;
    logic [4:0]        state_next;
    logic [LEN_W-1:0]  count_reg;
    logic [LEN_W-1:0]  count_next;
    logic [LINE_W-1:0] line_reg;
    logic [LINE_W-1:0] line_next;
    logic [7:0]        lex_reg [KW_MAX_LEN];

    logic              accept;
    logic              eof;
    step_t             p1;
    step_t             p2;
    logic              keep1;
    logic [LEN_W-1:0]  len1;
    logic              use2;
    logic              kw_hit;
    logic [4:0]        kw_idx;
    logic              room;
    push_t             push;
    token_t            out_tok;

    assign eof      = s_tuser[0];
    assign s_tready = room;
    assign accept   = s_tvalid && s_tready;

    assign p1    = scan_step(state_reg, s_tdata, eof);
    assign p2    = scan_step(ST_START, s_tdata, eof);
    assign keep1 = p1.keep && (count_reg < LEN_W'(LEXEME_MAX));
    assign len1  = count_reg + {{(LEN_W-1){1'b0}}, keep1};
    assign use2  = p1.done && p1.again;

    lex_kw_match u_kw
    (
        .lexeme (lex_reg),
        .length (count_reg),
        .hit    (kw_hit),
        .index  (kw_idx)
    );

    always_comb
    begin
        push.push0 = accept && p1.done;
        push.push1 = accept && use2 && p2.done;
        push.tok0.kind          = p1.kind;
        push.tok0.keyword_index = 5'd0;
        if (p1.kind == K_IDENT && kw_hit)
        begin
            push.tok0.kind          = K_KEYWORD;
            push.tok0.keyword_index = kw_idx;
        end
        push.tok0.lexeme_length = len1;
        push.tok0.line_number   = line_reg;
        push.tok0.last_of_run   = !(use2 && p2.done);
        push.tok1.kind          = p2.kind;
        push.tok1.keyword_index = 5'd0;
        push.tok1.lexeme_length = {{(LEN_W-1){1'b0}}, p2.keep};
        push.tok1.line_number   = line_reg;
        push.tok1.last_of_run   = 1'b1;

        if (!p1.done)
        begin
            state_next = p1.next_state;
            count_next = len1;
        end
        else if (use2 && !p2.done)
        begin
            state_next = p2.next_state;
            count_next = {{(LEN_W-1){1'b0}}, p2.keep};
        end
        else
        begin
            state_next = ST_START;
            count_next = '0;
        end

        line_next = line_reg;
        if (!eof && s_tdata == 8'h0A && line_reg != {LINE_W{1'b1}})
        begin
            line_next = line_reg + LINE_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (use2)
            begin
                if (p2.keep)
                begin
                    lex_reg[0] <= s_tdata;
                end
            end
            else if (keep1 && count_reg < LEN_W'(KW_MAX_LEN))
            begin
                lex_reg[count_reg[3:0]] <= s_tdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_START;
            count_reg <= '0;
            line_reg  <= LINE_W'(1);
        end
        else if (accept)
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            line_reg  <= line_next;
        end
    end

    lex_out_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (out_tok)
    );

    assign m_tdata = {out_tok.line_number, out_tok.lexeme_length,
                      out_tok.keyword_index, out_tok.kind};
    assign m_tlast = out_tok.last_of_run;

`include "assert_macros.svh"

    `ASSERT_NEXT(a_line_step, clk, rst_n,
        accept && !eof && s_tdata == 8'h0A,
        line_reg == $past(line_reg) + 16'd1 || line_reg == 16'hFFFF,
        "line counter did not advance on newline")
    `ASSERT_ALWAYS(a_len_cap, clk, rst_n, count_reg <= LEN_W'(LEXEME_MAX),
        "lexeme count above buffer size")
    `ASSERT_NEXT(a_second_last, clk, rst_n, push.push1,
        m_tvalid, "second token lost")

endmodule
`default_nettype wire

// File: sv/lex_kw_match.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lex_kw_match
// Parallel compare of the held lexeme prefix against the reserved words.
// ----------------------------------------------------------------------------
module lex_kw_match
    import lex_pkg::*;
(
    input  wire logic [7:0]       lexeme [KW_MAX_LEN],
    input  wire logic [LEN_W-1:0] length,
    output logic                  hit,
    output logic [4:0]            index
);

    logic [KEYWORD_COUNT-1:0] match;

    always_comb
    begin
        for (int k = 0; k < KEYWORD_COUNT; k++)
        begin
            match[k] = (length == KW_LEN[k]);
            for (int j = 0; j < KW_MAX_LEN; j++)
            begin
                if (j < int'(KW_LEN[k]))
                begin
                    if (lexeme[j] != KW_TEXT[k][(int'(KW_LEN[k]) - 1 - j) * 8 +: 8])
                    begin
                        match[k] = 1'b0;
                    end
                end
            end
        end
        hit   = |match;
        index = 5'd0;
        for (int k = KEYWORD_COUNT - 1; k >= 0; k--)
        begin
            if (match[k])
            begin
                index = 5'(k);
            end
        end
    end

endmodule
`default_nettype wire

// File: sv/lex_out_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lex_out_fifo
// Four-entry token queue; takes up to two tokens per cycle, gives one while out_ready is high.
// ----------------------------------------------------------------------------
module lex_out_fifo
    import lex_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire push_t  push,
    output logic        room,
    output logic        out_valid,
    input  wire logic   out_ready,
    output token_t      out_tok
);

    token_t     mem_reg [4];
    logic [1:0] wr_reg;
    logic [1:0] wr_next;
    logic [1:0] rd_reg;
    logic [1:0] rd_next;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic       pop;
    logic [2:0] pushed;

    assign room      = (cnt_reg <= 3'd2);
    assign out_valid = (cnt_reg != 3'd0);
    assign out_tok   = mem_reg[rd_reg];
    assign pop       = out_valid && out_ready;
    assign pushed    = {2'b00, push.push0} + {2'b00, push.push1};

    always_comb
    begin
        wr_next  = wr_reg + pushed[1:0];
        rd_next  = rd_reg + {1'b0, pop};
        cnt_next = cnt_reg + pushed - {2'b00, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push.push0)
        begin
            mem_reg[wr_reg] <= push.tok0;
        end
        if (push.push1)
        begin
            mem_reg[wr_reg + 2'd1] <= push.tok1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 2'd0;
            rd_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire
